/* rtl/core/lccs_pkg.sv */
`timescale 1ns / 1ps

package lccs_pkg;

  localparam logic [7:0] CMD_DATA     = 8'h00;
  localparam logic [7:0] CMD_SEEK     = 8'h01;
  localparam logic [7:0] CMD_TELL     = 8'h02;
  localparam logic [7:0] CMD_RESET    = 8'h03;
  localparam logic [7:0] CMD_INTERVAL = 8'h04;
  localparam logic [7:0] CMD_IDENTIFY = 8'h2A;
  localparam logic [7:0] CMD_UNLOCK   = 8'h33;
  localparam logic [7:0] CMD_LOCK     = 8'hF3;

  localparam logic [7:0] ANS_IDENTIFY = 8'hD5;
  localparam logic [7:0] ANS_UNKNOWN  = 8'h3F;

  localparam logic [15:0] DEFAULT_INTERVAL_RST = 16'd2;

  typedef enum logic [3:0] {
    PH_CMD      = 4'b0001,
    PH_DATA     = 4'b0010,
    PH_SEEK     = 4'b0100,
    PH_INTERVAL = 4'b1000
  } phase_e;

endpackage

/* rtl/core/led_cube_command_and_scan.sv */
`timescale 1ns / 1ps

// LED cube command parser and layer scanner. Each input word is either a
// received serial byte (func_i = 0) or a one-millisecond tick (func_i = 1);
// each word yields exactly one output word with the optional answer byte and
// the column and layer drives after that word took effect. A new word is
// accepted every cycle unless out_stall_i holds a full read stage and output
// register; a result passes through the layer memory read and then the
// output register. The layer memory is a synchronous array with one read
// and one byte-enabled write port; per-entry valid bits make it read as zero
// after reset and after the reset command, so no clearing pass is needed.
// The user must write default_interval through cfg_we_i/cfg_wdata_i only
// while the block is idle; the block itself does not enforce this.
module led_cube_command_and_scan
  import lccs_pkg::*;
#(
  parameter int LAYERS      = 2,
  parameter int LAYER_BYTES = 1,
  parameter int COLUMNS     = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               func_i,
  input  logic [7:0]         rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               answer_valid_o,
  output logic [7:0]         answer_byte_o,
  output logic [COLUMNS-1:0] column_drive_o,
  output logic [LAYERS-1:0]  layer_drive_o
);

  localparam int LW   = (LAYERS > 1) ? $clog2(LAYERS) : 1;
  localparam int IDXW = (LAYER_BYTES > 1) ? $clog2(LAYER_BYTES) : 1;
  localparam int DW   = 8 * LAYER_BYTES;
  localparam int CW   = (COLUMNS < DW) ? COLUMNS : DW;

  function automatic logic [LW-1:0] mod_layers(input logic [7:0] b);
    logic [11:0] r;
    r = {4'b0, b};
    for (int k = 7; k >= 0; k--) begin
      if (r >= 12'(LAYERS << k)) begin
        r = r - 12'(LAYERS << k);
      end
    end
    return LW'(r);
  endfunction

  // control state
  logic [15:0]       dflt_intv_q;
  logic              lock_q, lock_d;
  phase_e            phase_q, phase_d;
  logic [IDXW-1:0]   idx_q, idx_d;
  logic [7:0]        wpos_q, wpos_d;
  logic [LW-1:0]     slot_q, slot_d;
  logic [15:0]       intv_q, intv_d;
  logic [LAYERS-1:0] vld_q, vld_d;
  logic [LW-1:0]     shown_q, shown_d;
  logic [15:0]       cnt_q, cnt_d;

  logic              accept;
  logic              adv_layer;
  logic [15:0]       cnt_inc;
  logic              ans_v;
  logic [7:0]        ans_b;

  // memory write
  logic                   we;
  logic [LAYER_BYTES-1:0] wbe;
  logic [DW-1:0]          wdata;
  logic [DW-1:0]          mem_q [LAYERS];

  // read stage
  logic                   p1_valid_q;
  logic                   p1_ans_v_q;
  logic [7:0]             p1_ans_b_q;
  logic                   p1_lock_q;
  logic [LW-1:0]          p1_shown_q;
  logic                   p1_ent_vld_q;
  logic                   p1_fwd_q;
  logic [LAYER_BYTES-1:0] p1_be_q;
  logic [DW-1:0]          p1_wdata_q;
  logic [DW-1:0]          rd_q;
  logic                   p1_adv;

  logic [DW-1:0]          p1_data;
  logic [COLUMNS-1:0]     p1_cols;
  logic [LAYERS-1:0]      p1_lays;

  // output register
  logic                   out_valid_q;
  logic                   ans_v_q;
  logic [7:0]             ans_b_q;
  logic [COLUMNS-1:0]     cols_q;
  logic [LAYERS-1:0]      lays_q;

  assign p1_adv     = !out_valid_q || !out_stall_i;
  assign in_stall_o = p1_valid_q && !p1_adv;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    lock_d    = lock_q;
    phase_d   = phase_q;
    idx_d     = idx_q;
    wpos_d    = wpos_q;
    slot_d    = slot_q;
    intv_d    = intv_q;
    vld_d     = vld_q;
    shown_d   = shown_q;
    cnt_d     = cnt_q;
    adv_layer = 1'b0;
    cnt_inc   = cnt_q + 16'd1;
    ans_v     = 1'b0;
    ans_b     = 8'h00;
    we        = 1'b0;

    for (int j = 0; j < LAYER_BYTES; j++) begin
      wbe[j]          = !vld_q[slot_q] || (idx_q == IDXW'(j));
      wdata[j*8 +: 8] = (idx_q == IDXW'(j)) ? rx_byte_i : 8'h00;
    end

    if (accept) begin
      if (func_i) begin
        if (!lock_q) begin
          if (cnt_inc >= intv_q) begin
            adv_layer = 1'b1;
          end else begin
            cnt_d = cnt_inc;
          end
        end
      end else begin
        unique case (phase_q)
          PH_DATA: begin
            we            = 1'b1;
            vld_d[slot_q] = 1'b1;
            if (idx_q == IDXW'(LAYER_BYTES - 1)) begin
              idx_d   = '0;
              wpos_d  = wpos_q + 8'd1;
              slot_d  = (wpos_q == 8'hFF || slot_q == LW'(LAYERS - 1)) ? '0
                                                                       : slot_q + LW'(1);
              phase_d = PH_CMD;
            end else begin
              idx_d = idx_q + IDXW'(1);
            end
          end
          PH_SEEK: begin
            wpos_d  = rx_byte_i;
            slot_d  = mod_layers(rx_byte_i);
            phase_d = PH_CMD;
          end
          PH_INTERVAL: begin
            intv_d  = {8'h00, rx_byte_i};
            phase_d = PH_CMD;
          end
          PH_CMD: begin
            if (!lock_q || rx_byte_i == CMD_UNLOCK) begin
              unique case (rx_byte_i)
                CMD_DATA: begin
                  phase_d = PH_DATA;
                  idx_d   = '0;
                end
                CMD_SEEK:     phase_d = PH_SEEK;
                CMD_TELL: begin
                  ans_v = 1'b1;
                  ans_b = 8'(slot_q);
                end
                CMD_RESET: begin
                  vld_d  = '0;
                  wpos_d = 8'h00;
                  slot_d = '0;
                  intv_d = dflt_intv_q;
                end
                CMD_INTERVAL: phase_d = PH_INTERVAL;
                CMD_IDENTIFY: begin
                  ans_v = 1'b1;
                  ans_b = ANS_IDENTIFY;
                end
                CMD_UNLOCK: begin
                  lock_d    = 1'b0;
                  adv_layer = 1'b1;
                end
                CMD_LOCK:     lock_d = 1'b1;
                default: begin
                  ans_v = 1'b1;
                  ans_b = ANS_UNKNOWN;
                end
              endcase
            end
          end
          default: phase_d = PH_CMD;
        endcase
      end
      if (adv_layer) begin
        shown_d = (shown_q == LW'(LAYERS - 1)) ? '0 : shown_q + LW'(1);
        cnt_d   = 16'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dflt_intv_q <= DEFAULT_INTERVAL_RST;
      lock_q      <= 1'b1;
      phase_q     <= PH_CMD;
      idx_q       <= '0;
      wpos_q      <= 8'h00;
      slot_q      <= '0;
      intv_q      <= DEFAULT_INTERVAL_RST;
      vld_q       <= '0;
      shown_q     <= LW'(LAYERS - 1);
      cnt_q       <= 16'd0;
      p1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        dflt_intv_q <= cfg_wdata_i;
      end
      lock_q  <= lock_d;
      phase_q <= phase_d;
      idx_q   <= idx_d;
      wpos_q  <= wpos_d;
      slot_q  <= slot_d;
      intv_q  <= intv_d;
      vld_q   <= vld_d;
      shown_q <= shown_d;
      cnt_q   <= cnt_d;
      if (accept) begin
        p1_valid_q <= 1'b1;
      end else if (p1_adv) begin
        p1_valid_q <= 1'b0;
      end
      if (p1_adv) begin
        out_valid_q <= p1_valid_q;
      end
    end
  end

  // layer memory: read of the new shown layer, byte-enabled write
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q <= mem_q[shown_d];
    end
    if (we) begin
      for (int j = 0; j < LAYER_BYTES; j++) begin
        if (wbe[j]) begin
          mem_q[slot_q][j*8 +: 8] <= wdata[j*8 +: 8];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      p1_ans_v_q   <= ans_v;
      p1_ans_b_q   <= ans_b;
      p1_lock_q    <= lock_d;
      p1_shown_q   <= shown_d;
      p1_ent_vld_q <= vld_d[shown_d];
      p1_fwd_q     <= we && (slot_q == shown_d);
      p1_be_q      <= wbe;
      p1_wdata_q   <= wdata;
    end
  end

  // same-entry write forwarding over the read-before-write memory
  always_comb begin
    for (int j = 0; j < LAYER_BYTES; j++) begin
      p1_data[j*8 +: 8] = (p1_fwd_q && p1_be_q[j]) ? p1_wdata_q[j*8 +: 8]
                                                  : rd_q[j*8 +: 8];
    end
    if (!p1_ent_vld_q || p1_lock_q) begin
      p1_data = '0;
    end
    p1_cols         = '0;
    p1_cols[CW-1:0] = p1_data[CW-1:0];
    p1_lays         = p1_lock_q ? '0 : (LAYERS'(1) << p1_shown_q);
  end

  always_ff @(posedge clk_i) begin
    if (p1_adv && p1_valid_q) begin
      ans_v_q <= p1_ans_v_q;
      ans_b_q <= p1_ans_b_q;
      cols_q  <= p1_cols;
      lays_q  <= p1_lays;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign answer_valid_o = ans_v_q;
  assign answer_byte_o  = ans_b_q;
  assign column_drive_o = cols_q;
  assign layer_drive_o  = lays_q;

endmodule
